// ----- sv/alias_pattern_matcher_top_defines.svh -----
// Assertion macros for the alias pattern matcher.
// Included by the modules that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef ALIAS_PATTERN_MATCHER_TOP_DEFINES_SVH
`define ALIAS_PATTERN_MATCHER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define APM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define APM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/apm_pkg.sv -----
// Shared constants, command codes and the cell control struct of the alias pattern matcher.
// No dependencies; imported by apm_cell, alias_pattern_matcher_top and the testbench.
package apm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int ALPHABET    = 26;
	localparam int LETTER_W    = 5;
	localparam int SLOT_W      = 6;
	localparam int CMD_W       = 2;
	localparam int LEN_W       = 7;
	localparam int POS_W       = 20;
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	// Command codes of an input item
	localparam logic [CMD_W-1:0] CMD_ALIAS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

	// Register index of pattern_length
	localparam logic [APB_ADDR_W-3:0] REG_LEN_IDX = '0;

	// Broadcast control to every cell of the row
	typedef struct packed {
		logic                shift;
		logic                rotate;
		logic                alias_wr;
		logic [SLOT_W-1:0]   alias_src;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] alias_val;
	} cell_ctl_t;

endpackage

// ----- sv/alias_pattern_matcher_top.sv -----
// Top level of the alias pattern matcher: APB register, item handshakes and the cell row.
// Depends on apm_pkg, apm_cell and alias_pattern_matcher_top_defines.svh.
// The block takes one item per cycle while results are taken: a text letter shifts into a row
// of 64 cells, each comparing its window entry with its pattern letter and that letter's alias
// in the same cycle; the match bits are registered in the cells, then ANDed into the output
// register once the output register is free. Alias, pattern and restart items give no result.
// The pattern is held as a ring aligned to the current pattern_length; after a write to
// pattern_length the ring rotates one cell per cycle until it is aligned again, and no item
// is accepted meanwhile. Results begin once as many letters as the clamped pattern_length
// have arrived since the last restart.
`include "alias_pattern_matcher_top_defines.svh"
module alias_pattern_matcher_top import apm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// Input items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [LETTER_W-1:0]   letter,
	// Result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  match,
	output logic [POS_W-1:0]      start_position
);

	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    ring_lm1_q;
	logic [IDX_W-1:0]    target_lm1;
	logic                busy;
	logic [LEN_W-1:0]    fill_q;
	logic [LEN_W-1:0]    fill_next;
	logic [LEN_W-1:0]    eff_len;
	logic [POS_W-1:0]    chars_q;
	logic [POS_W-1:0]    chars_next;
	logic [LETTER_W-1:0] alias_q [ALPHABET];
	logic [LETTER_W-1:0] alias_rd;
	logic                reg_sel;
	logic                cfg_wr;
	logic                accept;
	logic                text_acc;
	logic                result_acc;
	logic                alias_ok;
	logic                pat_acc;
	logic [IDX_W-1:0]    pat_idx;
	logic                s1_v_q;
	logic                s1_adv;
	logic [POS_W-1:0]    start_s1;
	logic                out_v_q;
	logic                match_q;
	logic [POS_W-1:0]    start_q;
	cell_ctl_t           ctl;
	logic [LETTER_W-1:0] w_row [MAX_PATTERN];
	logic [LETTER_W-1:0] p_row [MAX_PATTERN];
	logic [LETTER_W-1:0] a_row [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] hits;
	logic [MAX_PATTERN-1:0] pat_wr;
	logic [MAX_PATTERN-1:0] in_window;

	// Register access
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_LEN_IDX);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(APB_DATA_W-LEN_W){1'b0}}, len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_wr) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	// Clamp the length into 1..MAX_PATTERN, kept as length minus one
	always_comb begin
		if (len_q == '0) begin
			target_lm1 = '0;
		end else if (len_q > LEN_W'(MAX_PATTERN)) begin
			target_lm1 = IDX_W'(MAX_PATTERN - 1);
		end else begin
			target_lm1 = IDX_W'(len_q - LEN_W'(1));
		end
	end

	// Rotate the pattern ring until it matches the current length
	assign busy = (ring_lm1_q != target_lm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_lm1_q <= '0;
		end else if (busy) begin
			ring_lm1_q <= ring_lm1_q + IDX_W'(1);
		end
	end

	// Handshake: hold input off while realigning or while the result path is full
	assign s1_adv   = s1_v_q && (!out_v_q || out_ready);
	assign in_ready = (!s1_v_q || s1_adv) && !busy;
	assign accept   = in_valid && in_ready;
	assign text_acc = accept && (cmd == CMD_TEXT);

	// Text position and fill level
	assign fill_next  = (fill_q == LEN_W'(MAX_PATTERN)) ? fill_q : fill_q + LEN_W'(1);
	assign chars_next = chars_q + POS_W'(1);
	assign eff_len    = {1'b0, ring_lm1_q} + LEN_W'(1);
	assign result_acc = text_acc && (fill_next >= eff_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			chars_q <= '0;
		end else if (accept && (cmd == CMD_RESTART)) begin
			fill_q  <= '0;
			chars_q <= '0;
		end else if (text_acc) begin
			fill_q  <= fill_next;
			chars_q <= chars_next;
		end
	end

	// Alias table
	assign alias_ok = (32'(slot) < ALPHABET);

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_ALIAS) && alias_ok) begin
			alias_q[slot[LETTER_W-1:0]] <= letter;
		end
	end

	assign alias_rd = (32'(letter) < ALPHABET) ? alias_q[letter] : letter;

	// Pattern write lands in the cell aligned to the current length
	assign pat_acc = accept && (cmd == CMD_PATTERN) && (32'(slot) < MAX_PATTERN);
	assign pat_idx = ring_lm1_q - slot[IDX_W-1:0];

	// Broadcast control to the row
	always_comb begin
		ctl.shift     = text_acc;
		ctl.rotate    = busy;
		ctl.alias_wr  = accept && (cmd == CMD_ALIAS) && alias_ok;
		ctl.alias_src = slot;
		ctl.letter    = letter;
		ctl.alias_val = alias_rd;
	end

	// Row of cells
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		assign pat_wr[k]    = pat_acc && (pat_idx == IDX_W'(k));
		assign in_window[k] = (IDX_W'(k) <= ring_lm1_q);

		apm_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pat_wr    (pat_wr[k]),
			.in_window (in_window[k]),
			.w_prev    ((k == 0) ? letter : w_row[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
			.p_prev    (p_row[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
			.a_prev    (a_row[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
			.w         (w_row[k]),
			.p         (p_row[k]),
			.a         (a_row[k]),
			.hit       (hits[k])
		);
	end

	// Compare stage: position travels beside the cells' match bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (result_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_acc) begin
			start_s1 <= chars_next - {{(POS_W-IDX_W){1'b0}}, ring_lm1_q} - POS_W'(1);
		end
	end

	// Output register: AND the match bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			match_q <= &hits;
			start_q <= start_s1;
		end
	end

	assign out_valid      = out_v_q;
	assign match          = match_q;
	assign start_position = start_q;

	`APM_ASSERT_SAME(a_busy_blocks_input, busy, !in_ready, "item accepted during ring realignment")
	`APM_ASSERT_NEXT(a_ring_steps_by_one, busy, ring_lm1_q == $past(ring_lm1_q) + 1'b1, "ring skipped a step")
	`APM_ASSERT_NEXT(a_s1_holds, (s1_v_q && !s1_adv), s1_v_q, "compare stage dropped an item")
	`APM_ASSERT_SAME(a_fill_bounded, 1'b1, fill_q <= LEN_W'(MAX_PATTERN), "fill level beyond window")

endmodule

// ----- sv/apm_cell.sv -----
// One cell of the comparator row: a text window entry, a pattern letter and its alias.
// Depends on apm_pkg for widths and the cell control struct.
module apm_cell import apm_pkg::*; (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic                pat_wr,
	input  logic                in_window,
	input  logic [LETTER_W-1:0] w_prev,
	input  logic [LETTER_W-1:0] p_prev,
	input  logic [LETTER_W-1:0] a_prev,
	output logic [LETTER_W-1:0] w,
	output logic [LETTER_W-1:0] p,
	output logic [LETTER_W-1:0] a,
	output logic                hit
);

	logic [LETTER_W-1:0] w_q;
	logic [LETTER_W-1:0] p_q;
	logic [LETTER_W-1:0] a_q;
	logic                hit_s1;

	// Shift the text letter in and compare the incoming letter against pattern and alias
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			w_q    <= w_prev;
			hit_s1 <= !in_window || (w_prev == p_q) || (w_prev == a_q);
		end
	end

	// Rotate the pattern ring, load a pattern letter, or follow an alias table write
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			p_q <= p_prev;
			a_q <= a_prev;
		end else if (pat_wr) begin
			p_q <= ctl.letter;
			a_q <= ctl.alias_val;
		end else if (ctl.alias_wr && ({1'b0, p_q} == ctl.alias_src)) begin
			a_q <= ctl.letter;
		end
	end

	assign w   = w_q;
	assign p   = p_q;
	assign a   = a_q;
	assign hit = hit_s1;

endmodule

// ----- sim/alias_pattern_matcher_top_test.sv -----
`timescale 1ns / 100ps
// Testbench for alias_pattern_matcher_top: loads the alias and pattern tables, streams text
// and checks every result against a predictor kept in step with the items sent.
// Depends on apm_pkg and the alias_pattern_matcher_top RTL only.
module alias_pattern_matcher_top_test;
	import apm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_LEN_IDX, 2'b00};

	typedef struct packed {
		logic            hit;
		logic [POS_W-1:0] pos;
	} window_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [SLOT_W-1:0]     slot;
	logic [LETTER_W-1:0]   letter;
	logic                  out_valid;
	logic                  out_ready;
	logic                  match;
	logic [POS_W-1:0]      start_position;

	// Predicted window results, oldest first
	window_result_t expected_windows[$];

	// Predictor state
	logic [LETTER_W-1:0] pm_pattern [MAX_PATTERN];
	logic [LETTER_W-1:0] pm_alias [ALPHABET];
	logic [LETTER_W-1:0] pm_window [MAX_PATTERN];
	logic [POS_W-1:0]    pm_count;
	int                  pm_fill;
	logic [LEN_W-1:0]    pm_len;

	// Stimulus-side copy of the tables, used to build matching windows
	logic [LETTER_W-1:0] st_pattern [MAX_PATTERN];
	logic [LETTER_W-1:0] st_alias [ALPHABET];
	int                  st_len;

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int cycle_count;
	int items_sent;
	int results_seen;
	int hits_seen;

	alias_pattern_matcher_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.slot           (slot),
		.letter         (letter),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match          (match),
		.start_position (start_position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a pattern_length value to the range the block acts on
	function automatic int eff_len(logic [LEN_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_PATTERN) return MAX_PATTERN;
		return int'(v);
	endfunction

	// Update the predictor with one accepted item and queue its result, if any
	task automatic predict_item(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
			logic [LETTER_W-1:0] l);
		int n;
		logic ok;
		logic [LETTER_W-1:0] pc;
		logic [LETTER_W-1:0] tc;
		logic [LETTER_W-1:0] ac;
		window_result_t wr;
		case (c)
			CMD_ALIAS: begin
				if (s < ALPHABET) pm_alias[s] = l;
			end
			CMD_PATTERN: begin
				pm_pattern[s] = l;
			end
			CMD_RESTART: begin
				foreach (pm_window[i]) pm_window[i] = '0;
				pm_count = '0;
				pm_fill = 0;
			end
			CMD_TEXT: begin
				for (int i = MAX_PATTERN - 1; i > 0; i--) pm_window[i] = pm_window[i-1];
				pm_window[0] = l;
				pm_count = pm_count + 1'b1;
				if (pm_fill < MAX_PATTERN) pm_fill++;
				n = eff_len(pm_len);
				if (pm_fill >= n) begin
					ok = 1'b1;
					for (int j = 0; j < n; j++) begin
						pc = pm_pattern[j];
						tc = pm_window[n-1-j];
						ac = (pc < ALPHABET) ? pm_alias[pc] : pc;
						if (tc != pc && tc != ac) ok = 1'b0;
					end
					wr.hit = ok;
					wr.pos = pm_count - POS_W'(n);
					expected_windows = {expected_windows, wr};
				end
			end
			default: begin
			end
		endcase
	endtask

	// Check results, then follow accepted items and register writes
	always @(posedge clk) begin : scoreboard
		window_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_windows.size() == 0) begin
					error_count++;
					$error("result with nothing expected: match %0d start_position %0d",
						match, start_position);
				end else begin
					want = expected_windows.pop_front();
					if (want.hit) hits_seen++;
					if (match !== want.hit) begin
						error_count++;
						$error("match: expected %0d, actual %0d", want.hit, match);
					end
					if (start_position !== want.pos) begin
						error_count++;
						$error("start_position: expected %0d, actual %0d", want.pos,
							start_position);
					end
				end
			end
			if (in_valid && in_ready) predict_item(cmd, slot, letter);
			if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
				pm_len = pwdata[LEN_W-1:0];
		end
	end

	// Stall the result side at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped at cycle %0d with %0d results outstanding", cycle_count,
				expected_windows.size());
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item, idling first at the sender rate; return once it is accepted
	task automatic send_item(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
			logic [LETTER_W-1:0] l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		slot <= s;
		letter <= l;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic put_alias(logic [SLOT_W-1:0] s, logic [LETTER_W-1:0] l);
		if (s < ALPHABET) st_alias[s] = l;
		send_item(CMD_ALIAS, s, l);
	endtask

	task automatic put_pattern(logic [SLOT_W-1:0] s, logic [LETTER_W-1:0] l);
		st_pattern[s] = l;
		send_item(CMD_PATTERN, s, l);
	endtask

	task automatic put_text(logic [LETTER_W-1:0] l);
		send_item(CMD_TEXT, SLOT_W'($urandom_range(63)), l);
	endtask

	task automatic put_restart();
		send_item(CMD_RESTART, SLOT_W'($urandom_range(63)), LETTER_W'($urandom_range(31)));
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write pattern_length through the APB port; the block must be idle
	task automatic write_length(logic [LEN_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		st_len = eff_len(v);
	endtask

	// Random traffic: mostly windows built from the pattern, plus noise and table rewrites
	task automatic random_traffic(int n);
		int done;
		int pick;
		int bad;
		int run;
		logic [SLOT_W-1:0] s;
		logic [LETTER_W-1:0] pc;
		logic [LETTER_W-1:0] tl;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// one window of pattern letters or their aliases, sometimes with one bad letter
				bad = ($urandom_range(99) < 35) ? $urandom_range(st_len - 1) : -1;
				for (int j = 0; j < st_len; j++) begin
					pc = st_pattern[j];
					tl = (pc < ALPHABET && $urandom_range(1)) ? st_alias[pc] : pc;
					if (j == bad) tl = LETTER_W'($urandom_range(31));
					put_text(tl);
				end
				done += st_len;
			end else if (pick < 75) begin
				run = $urandom_range(1, 6);
				repeat (run) put_text(LETTER_W'($urandom_range(31)));
				done += run;
			end else if (pick < 85) begin
				s = SLOT_W'($urandom_range(63));
				put_alias(s, LETTER_W'($urandom_range(31)));
				if (s < ALPHABET) done++;
			end else if (pick < 95) begin
				s = SLOT_W'($urandom_range(63));
				if ($urandom_range(99) < 80)
					put_pattern(s, LETTER_W'($urandom_range(ALPHABET - 1)));
				else
					put_pattern(s, LETTER_W'($urandom_range(ALPHABET, 31)));
				done++;
			end else begin
				put_restart();
				done++;
			end
		end
	endtask

	// Two halves at two lengths; the second length takes effect mid-text
	task automatic run_phase(int idle, int stall, logic [LEN_W-1:0] len_a,
			logic [LEN_W-1:0] len_b, int n);
		wait_drain();
		send_idle_pct = idle;
		recv_stall_pct = stall;
		write_length(len_a);
		random_traffic(n / 2);
		wait_drain();
		write_length(len_b);
		random_traffic(n - n / 2);
	endtask

	// Fill every alias and pattern entry so that no unwritten entry is ever read
	task automatic test_load_tables();
		for (int i = 0; i < ALPHABET; i++)
			put_alias(SLOT_W'(i), LETTER_W'($urandom_range(ALPHABET - 1)));
		for (int i = 0; i < MAX_PATTERN; i++)
			put_pattern(SLOT_W'(i), LETTER_W'($urandom_range(ALPHABET - 1)));
	endtask

	// Field extremes, ignored alias slots, out-of-range letters and a zero length
	task automatic test_directed();
		wait_drain();
		write_length(LEN_W'(2));
		put_alias(SLOT_W'(ALPHABET), 5'd31);
		put_alias(SLOT_W'(63), 5'd31);
		put_alias(SLOT_W'(0), 5'd25);
		put_pattern(SLOT_W'(0), 5'd31);
		put_pattern(SLOT_W'(1), 5'd0);
		put_pattern(SLOT_W'(63), 5'd31);
		put_restart();
		put_text(5'd31);
		put_text(5'd0);
		put_text(5'd25);
		put_text(5'd31);
		put_text(5'd25);
		put_text(5'd26);
		put_restart();
		wait_drain();
		write_length(LEN_W'(0));
		put_text(5'd31);
		put_text(5'd0);
		put_text(5'd30);
	endtask

	task automatic test_no_idling();
		run_phase(0, 0, LEN_W'(3), LEN_W'(127), 200);
	endtask

	task automatic test_sender_idle();
		run_phase(65, 0, LEN_W'(64), LEN_W'(1), 200);
	endtask

	task automatic test_receiver_stall();
		run_phase(0, 65, LEN_W'(2), LEN_W'(33), 200);
	endtask

	task automatic test_both_idle();
		run_phase(6, 6, LEN_W'(5), LEN_W'(64), 200);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_TEXT;
		slot <= '0;
		letter <= '0;
		out_ready <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		cycle_count = 0;
		items_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		foreach (pm_window[i]) pm_window[i] = '0;
		foreach (st_pattern[i]) st_pattern[i] = '0;
		foreach (st_alias[i]) st_alias[i] = '0;
		pm_count = '0;
		pm_fill = 0;
		pm_len = LEN_W'(1);
		st_len = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_tables();
		test_directed();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		wait_drain();

		if (expected_windows.size() != 0) begin
			error_count++;
			$error("%0d expected results never came out", expected_windows.size());
		end
		$display("sent %0d items, checked %0d window results (%0d matches)", items_sent,
			results_seen, hits_seen);
		$display("lengths 0 to 127 incl. mid-text changes, table rewrites, restarts, four pacings");
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
